/* rtl/ilpwe_pkg.sv */
// shared constants and types for the inverted led pulse width encoder
// no dependencies

package ilpwe_pkg;

  // width of the tick counter inside one bit
  localparam int CNT_W = 10;
  // width of each timing register
  localparam int CFG_W = 10;
  // width of the register index on the config port
  localparam int REG_IDX_W = 2;
  // width used for period compares, wide enough for 2^CNT_W and any register value
  localparam int PER_W = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;

  localparam int BYTE_W = 8;
  localparam int BITPOS_W = 3;

  // packed widths of the stream payloads
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 8;

  // reset values of the timing registers
  localparam logic [CFG_W-1:0] ZERO_LOW_RST = CFG_W'(30);
  localparam logic [CFG_W-1:0] ONE_LOW_RST = CFG_W'(80);
  localparam logic [CFG_W-1:0] BIT_PERIOD_RST = CFG_W'(120);

  // shortest legal bit period
  localparam logic [PER_W-1:0] PERIOD_MIN = PER_W'(2);
  // longest bit period the counter can time
  localparam logic [PER_W-1:0] PERIOD_MAX = PER_W'(1) << CNT_W;

  // register indexes on the config port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ZERO_LOW   = 2'd0,
    REG_ONE_LOW    = 2'd1,
    REG_BIT_PERIOD = 2'd2
  } reg_idx_t;

  // item kind carried on in_tuser
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_OFFER = 1'b1
  } op_t;

  // one result item
  typedef struct packed {
    logic underrun;
    logic space_free;
    logic byte_accepted;
    logic busy_res;
    logic pin_level;
  } result_t;

endpackage

/* rtl/inverted_led_pulse_width_encoder.sv */
// top level of the inverted led pulse width encoder: timing registers, bit
// timer, one-byte holding register and the result register
// depends on ilpwe_pkg
//
// the result item is registered and shown in the cycle after its input is accepted
// throughput: one item per cycle while not stalled; each item is one tick of
// the bit timer, updated in the accept cycle so the next item may follow at once
// the result register stalls intake only while it holds an item not yet taken
// reset (rst_n low, synchronous): timing registers to 30/80/120, encoder idle,
// holding register empty, no result pending

module inverted_led_pulse_width_encoder
  import ilpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  input  logic                  in_tuser,   // op
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] pin_level, [1] busy_res,
                                            // [2] byte_accepted, [3] space_free,
                                            // [4] underrun, [7:5] zero
  // config write port
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // timing registers
  logic [CFG_W-1:0] zero_low_r;
  logic [CFG_W-1:0] one_low_r;
  logic [CFG_W-1:0] bit_period_r;

  // encoder state
  logic [BYTE_W-1:0]   shift_byte_r, shift_byte_nxt;
  logic [BITPOS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [CNT_W-1:0]    tick_cnt_r, tick_cnt_nxt;
  logic [BYTE_W-1:0]   hold_byte_r, hold_byte_nxt;
  logic                hold_full_r, hold_full_nxt;
  logic                hold_final_r, hold_final_nxt;
  logic                cur_final_r, cur_final_nxt;
  logic                sending_r, sending_nxt;

  // result register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic              in_fire;
  logic [PER_W-1:0]  period;
  logic [PER_W-1:0]  period_raw;
  logic [PER_W-1:0]  low_time;
  logic [PER_W-1:0]  tick_next;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // clamp the bit period to what the counter can time
  assign period_raw = PER_W'(bit_period_r);
  always_comb begin
    priority if (period_raw < PERIOD_MIN) begin
      period = PERIOD_MIN;
    end else if (period_raw > PERIOD_MAX) begin
      period = PERIOD_MAX;
    end else begin
      period = period_raw;
    end
  end

  // one tick of the encoder
  always_comb begin
    shift_byte_nxt = shift_byte_r;
    bit_pos_nxt    = bit_pos_r;
    tick_cnt_nxt   = tick_cnt_r;
    hold_byte_nxt  = hold_byte_r;
    hold_full_nxt  = hold_full_r;
    hold_final_nxt = hold_final_r;
    cur_final_nxt  = cur_final_r;
    sending_nxt    = sending_r;
    res_nxt        = '0;
    res_nxt.pin_level = 1'b1;
    low_time       = '0;
    tick_next      = '0;

    // offer into the holding register if it was empty
    if (in_tuser == OP_OFFER && !hold_full_r) begin
      hold_byte_nxt         = in_tdata[BYTE_W-1:0];
      hold_final_nxt        = in_tlast;
      hold_full_nxt         = 1'b1;
      res_nxt.byte_accepted = 1'b1;
    end

    // idle with a byte waiting: start a frame on this tick
    if (!sending_r && hold_full_nxt) begin
      shift_byte_nxt = hold_byte_nxt;
      cur_final_nxt  = hold_final_nxt;
      hold_full_nxt  = 1'b0;
      bit_pos_nxt    = '0;
      tick_cnt_nxt   = '0;
      sending_nxt    = 1'b1;
    end

    // drive the current bit tick and advance the timer
    if (sending_nxt) begin
      low_time = shift_byte_nxt[BYTE_W-1] ? PER_W'(one_low_r) : PER_W'(zero_low_r);
      tick_next = PER_W'(tick_cnt_nxt) + PER_W'(1);
      res_nxt.busy_res  = 1'b1;
      res_nxt.pin_level = (PER_W'(tick_cnt_nxt) < low_time) ? 1'b0 : 1'b1;
      if (tick_next >= period) begin
        tick_cnt_nxt   = '0;
        shift_byte_nxt = {shift_byte_nxt[BYTE_W-2:0], 1'b0};
        if (bit_pos_nxt == BITPOS_W'(BYTE_W - 1)) begin
          bit_pos_nxt = '0;
          priority if (cur_final_nxt) begin
            sending_nxt = 1'b0;
          end else if (hold_full_nxt) begin
            // next byte follows with no gap
            shift_byte_nxt = hold_byte_nxt;
            cur_final_nxt  = hold_final_nxt;
            hold_full_nxt  = 1'b0;
            tick_cnt_nxt   = '0;
            sending_nxt    = 1'b1;
          end else begin
            res_nxt.underrun = 1'b1;
            sending_nxt      = 1'b0;
          end
        end else begin
          bit_pos_nxt = bit_pos_nxt + BITPOS_W'(1);
        end
      end else begin
        tick_cnt_nxt = tick_next[CNT_W-1:0];
      end
    end

    res_nxt.space_free = !hold_full_nxt;
  end

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_low_r   <= ZERO_LOW_RST;
      one_low_r    <= ONE_LOW_RST;
      bit_period_r <= BIT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ZERO_LOW:   zero_low_r   <= cfg_wdata;
        REG_ONE_LOW:    one_low_r    <= cfg_wdata;
        REG_BIT_PERIOD: bit_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // encoder state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_byte_r <= '0;
      bit_pos_r    <= '0;
      tick_cnt_r   <= '0;
      hold_byte_r  <= '0;
      hold_full_r  <= 1'b0;
      hold_final_r <= 1'b0;
      cur_final_r  <= 1'b0;
      sending_r    <= 1'b0;
    end else if (in_fire) begin
      shift_byte_r <= shift_byte_nxt;
      bit_pos_r    <= bit_pos_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      hold_byte_r  <= hold_byte_nxt;
      hold_full_r  <= hold_full_nxt;
      hold_final_r <= hold_final_nxt;
      cur_final_r  <= cur_final_nxt;
      sending_r    <= sending_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

endmodule

/* bench/led_line_checker.sv */
// result checker for the inverted led pulse width encoder: watches the config
// port and both stream channels, predicts every result item and compares it
// depends on ilpwe_pkg

module led_line_checker
  import ilpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  input  logic                  in_tuser,   // op
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [0] pin_level, [1] busy_res,
                                            // [2] byte_accepted, [3] space_free,
                                            // [4] underrun
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output logic                  line_idle
);

  timeunit 1ns;
  timeprecision 1ps;

  // timing registers as the encoder should hold them
  logic [CFG_W-1:0] zero_low;
  logic [CFG_W-1:0] one_low;
  logic [CFG_W-1:0] bit_period;

  // predicted encoder state
  logic [BYTE_W-1:0]   shift_reg;
  logic [BITPOS_W-1:0] bit_idx;
  logic [CNT_W-1:0]    tick_cnt;
  logic [BYTE_W-1:0]   hold_byte;
  logic                hold_full;
  logic                hold_last;
  logic                cur_last;
  logic                sending;

  // line results still owed by the encoder, oldest first
  result_t line_results_due[$];

  initial fail_count = 0;

  // move the holding byte into the shifter and start its first bit
  function automatic void load_held_byte();
    shift_reg = hold_byte;
    cur_last  = hold_last;
    hold_full = 1'b0;
    bit_idx   = '0;
    tick_cnt  = '0;
    sending   = 1'b1;
  endfunction

  // one tick of the encoder: take an offer, start or continue a bit
  function automatic result_t encode_tick(op_t op, logic [BYTE_W-1:0] db, logic fin);
    result_t          r;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] next_cnt;
    logic [CFG_W-1:0] low_len;
    r = '0;
    r.pin_level = 1'b1;
    if (op == OP_OFFER && !hold_full) begin
      hold_byte = db;
      hold_last = fin;
      hold_full = 1'b1;
      r.byte_accepted = 1'b1;
    end
    if (!sending && hold_full) load_held_byte();
    if (sending) begin
      period = PER_W'(bit_period);
      if (period < PERIOD_MIN) period = PERIOD_MIN;
      if (period > PERIOD_MAX) period = PERIOD_MAX;
      low_len  = shift_reg[BYTE_W-1] ? one_low : zero_low;
      next_cnt = PER_W'(tick_cnt) + PER_W'(1);
      r.busy_res  = 1'b1;
      r.pin_level = (PER_W'(tick_cnt) < PER_W'(low_len)) ? 1'b0 : 1'b1;
      if (next_cnt >= period) begin
        tick_cnt  = '0;
        shift_reg = shift_reg << 1;
        if (bit_idx == BITPOS_W'(7)) begin
          bit_idx = '0;
          if (cur_last) begin
            sending = 1'b0;
          end else if (hold_full) begin
            load_held_byte();
          end else begin
            // next byte missing at the byte boundary
            r.underrun = 1'b1;
            sending = 1'b0;
          end
        end else begin
          bit_idx = bit_idx + BITPOS_W'(1);
        end
      end else begin
        tick_cnt = CNT_W'(next_cnt);
      end
    end
    r.space_free = !hold_full;
    return r;
  endfunction

  // report the first hundred mismatches, count them all
  function automatic void check_bit(string field, logic want, logic got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 100) $error("%s: expected %0b, got %0b", field, want, got);
    end
  endfunction

  // config writes, result compare, then prediction for the accepted item
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      zero_low   = ZERO_LOW_RST;
      one_low    = ONE_LOW_RST;
      bit_period = BIT_PERIOD_RST;
      shift_reg  = '0;
      bit_idx    = '0;
      tick_cnt   = '0;
      hold_byte  = '0;
      hold_full  = 1'b0;
      hold_last  = 1'b0;
      cur_last   = 1'b0;
      sending    = 1'b0;
      line_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZERO_LOW:   zero_low = cfg_wdata;
          REG_ONE_LOW:    one_low = cfg_wdata;
          REG_BIT_PERIOD: bit_period = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (line_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 100) $error("result item arrived with none expected");
        end else begin
          want = line_results_due.pop_front();
          got  = result_t'(out_tdata[4:0]);
          check_bit("pin_level", want.pin_level, got.pin_level);
          check_bit("busy_res", want.busy_res, got.busy_res);
          check_bit("byte_accepted", want.byte_accepted, got.byte_accepted);
          check_bit("space_free", want.space_free, got.space_free);
          check_bit("underrun", want.underrun, got.underrun);
        end
      end
      if (in_tvalid && in_tready) begin
        line_results_due.push_back(encode_tick(op_t'(in_tuser), in_tdata[7:0], in_tlast));
      end
    end
    pending   = line_results_due.size();
    line_idle = !sending && !hold_full;
  end

endmodule

/* bench/inverted_led_pulse_width_encoder_tb.sv */
// stimulus and verdict for the inverted led pulse width encoder: directed
// frames, then random frames under several timing settings
// depends on ilpwe_pkg, the encoder and led_line_checker

module inverted_led_pulse_width_encoder_tb;

  import ilpwe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 300;
  // random items left when idling stops
  localparam int QUIET_ITEMS = 100;
  // bit period of the closing frame
  localparam int LAST_PERIOD = 12;
  // index past the last timing register, must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  int   fail_count;
  int   pending;
  logic line_idle;

  // random idling on each side
  logic        in_gaps;
  logic        out_gaps;
  int unsigned out_hold;
  int unsigned cycle_count;

  inverted_led_pulse_width_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  led_line_checker line_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .line_idle  (line_idle)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side drops ready in random bursts while out_gaps is set
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
    end else if (out_gaps && $urandom_range(0, 5) == 0) begin
      out_hold = $urandom_range(1, 10);
    end
    out_tready <= (out_hold == 0);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL inverted_led_pulse_width_encoder");
      $finish;
    end
  end

  // offer one item and hold it until the encoder takes it
  task automatic send_item(op_t op, logic [7:0] db, logic fin);
    logic taken;
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'(db);
    in_tlast  <= fin;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic run_ticks(int count);
    for (int i = 0; i < count; i++) send_item(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // sender holds off until every expected result item has come back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // tick the encoder until the line is idle and all results are in
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (!(line_idle && pending == 0)) begin
      @(posedge clk);
      if (!line_idle) begin
        send_item(OP_TICK, 8'($urandom), 1'($urandom));
        in_tvalid <= 1'b0;
      end
      @(negedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_timing(logic [CFG_W-1:0] zl, logic [CFG_W-1:0] ol,
                                logic [CFG_W-1:0] per);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_BIT_PERIOD, per);
    write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned      random_left;
    int unsigned      run_len;
    int unsigned      offer_pct;
    int unsigned      pause_at;
    logic             first_phase;
    logic [CFG_W-1:0] per;
    logic [CFG_W-1:0] zl;
    logic [CFG_W-1:0] ol;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tuser    = OP_TICK;
    out_tready  = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_ZERO_LOW;
    cfg_wdata   = '0;
    in_gaps     = 1'b1;
    out_gaps    = 1'b1;
    out_hold    = 0;
    cycle_count = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: ignored fields on a plain tick, then one final byte
    send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_OFFER, 8'h96, 1'b1);
    settle();

    // short bits: back-to-back bytes, refused offer, final byte, underrun
    program_timing(10'd1, 10'd2, 10'd3);
    send_item(OP_OFFER, 8'hFF, 1'b0);
    send_item(OP_OFFER, 8'h00, 1'b0);
    send_item(OP_OFFER, 8'hA5, 1'b1);
    run_ticks(30);
    send_item(OP_OFFER, 8'h80, 1'b1);
    settle();
    send_item(OP_OFFER, 8'h01, 1'b0);
    settle();
    send_item(OP_OFFER, 8'h7F, 1'b0);
    send_item(OP_OFFER, 8'hFE, 1'b1);
    settle();

    // period below two with zero low time: line stays high
    program_timing(10'd0, 10'd0, 10'd1);
    send_item(OP_OFFER, 8'h5A, 1'b1);
    settle();

    // zero period, zero bits low for the whole bit
    program_timing(10'h3FF, 10'd0, 10'd0);
    send_item(OP_OFFER, 8'hC3, 1'b1);
    settle();

    // random frames under random timing
    random_left = RANDOM_ITEMS;
    first_phase = 1'b1;
    while (random_left > 0) begin
      settle();
      case ($urandom_range(0, 7))
        0:       per = CFG_W'($urandom_range(0, 1));
        1, 2:    per = CFG_W'($urandom_range(11, 40));
        default: per = CFG_W'($urandom_range(2, 10));
      endcase
      zl = ($urandom_range(0, 7) == 0) ? 10'h3FF : CFG_W'($urandom_range(0, int'(per) + 1));
      ol = ($urandom_range(0, 7) == 0) ? 10'h3FF : CFG_W'($urandom_range(0, int'(per) + 1));
      program_timing(zl, ol, per);
      // no idling in the last part of the run
      in_gaps  = (random_left > QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      out_gaps = (random_left > QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      offer_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(8, 60);
      run_len = $urandom_range(120, 260);
      if (run_len > random_left) run_len = random_left;
      pause_at = (first_phase || $urandom_range(0, 3) == 0) ?
                 $urandom_range(1, run_len - 1) : run_len;
      for (int i = 0; i < run_len; i++) begin
        if (i == pause_at) wait_results();
        if ($urandom_range(1, 100) <= offer_pct) begin
          send_item(OP_OFFER, 8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_item(OP_TICK, 8'($urandom), 1'($urandom));
        end
      end
      random_left -= run_len;
      first_phase = 1'b0;
    end

    // zero low time far above the period, one low time of a single tick
    settle();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    program_timing(10'h3FF, 10'd1, CFG_W'(LAST_PERIOD));
    send_item(OP_OFFER, 8'h5C, 1'b1);
    run_ticks(8 * LAST_PERIOD - 1);
    settle();

    wait_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS inverted_led_pulse_width_encoder");
    end else begin
      $display("FAIL inverted_led_pulse_width_encoder");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ilpwe_pkg.sv
rtl/inverted_led_pulse_width_encoder.sv
bench/led_line_checker.sv
bench/inverted_led_pulse_width_encoder_tb.sv
